// File: rtl/core/htok_pkg.sv
package htok_pkg;

  localparam int QUERY_SLOTS  = 16;
  localparam int HEADER_SLOTS = 32;
  localparam int PairW        = 5;
  localparam int HdrW         = 6;
  localparam int OutqDepth    = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [2:0] {
    PH_METHOD, PH_PATH, PH_QUERY, PH_VERSION, PH_HEADER, PH_BODY
  } phase_e;

  typedef enum logic [3:0] {
    CLS_METHOD, CLS_PATH, CLS_QNAME, CLS_QVALUE, CLS_VERSION,
    CLS_HNAME, CLS_HVALUE, CLS_BODY, CLS_DELIM, CLS_DISCARD
  } cls_e;

  typedef enum logic [3:0] {
    FLD_NONE, FLD_METHOD, FLD_PATH, FLD_QNAME, FLD_QVALUE,
    FLD_VERSION, FLD_HNAME, FLD_HVALUE, FLD_DROPPED
  } fld_e;

  typedef enum logic [2:0] {
    MTH_UNKNOWN, MTH_GET, MTH_POST, MTH_PUT, MTH_DELETE, MTH_PATCH
  } mth_e;

  typedef enum logic [1:0] {
    ST_OK, ST_NO_SP_METHOD, ST_NO_SP_PATH, ST_NO_EOL
  } st_e;

  typedef struct packed {
    logic [7:0] data;
    cls_e       cls;
    logic [4:0] idx;
    fld_e       fld;
    mth_e       code;
    st_e        status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [2:0] verb_len(input logic [2:0] k);
    logic [2:0] l;
    case (k)
      3'd0:    l = 3'd3;
      3'd1:    l = 3'd4;
      3'd2:    l = 3'd3;
      3'd3:    l = 3'd6;
      3'd4:    l = 3'd5;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] verb_char(input logic [2:0] k, input logic [2:0] pos);
    logic [47:0] w;
    logic [47:0] sh;
    case (k)
      3'd0:    w = {"GET", 24'h0};
      3'd1:    w = {"POST", 16'h0};
      3'd2:    w = {"PUT", 24'h0};
      3'd3:    w = "DELETE";
      3'd4:    w = {"PATCH", 8'h0};
      default: w = 48'h0;
    endcase
    sh = w << {pos, 3'b000};
    return sh[47:40];
  endfunction

endpackage

// File: rtl/core/htok_parser.sv
module htok_parser
  import htok_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output push_t      push_o
);

  typedef struct packed {
    phase_e          phase;
    logic [4:0]      cand;
    logic [2:0]      mlen;
    logic [PairW-1:0] pairs;
    logic [HdrW-1:0] hdrs;
    logic            has_eq;
    logic            pair_empty;
    logic            q_halted;
    logic            held;
    logic            colon;
    logic            line_empty;
    logic            skip_sp;
  } pst_t;

  localparam pst_t PST_RESET = '{
    phase: PH_METHOD, cand: 5'h1F, mlen: 3'd0, pairs: '0, hdrs: '0,
    has_eq: 1'b0, pair_empty: 1'b1, q_halted: 1'b0, held: 1'b0,
    colon: 1'b0, line_empty: 1'b1, skip_sp: 1'b0};

  pst_t       st_q, st_d;
  pst_t       s;
  res_t       res [2];
  res_t       r;
  logic [1:0] n;
  logic       done;
  mth_e       code;

  function automatic res_t mk(input logic [7:0] b, input cls_e c, input logic [4:0] idx,
                              input fld_e f, input mth_e m);
    res_t x;
    x.data   = b;
    x.cls    = c;
    x.idx    = idx;
    x.fld    = f;
    x.code   = m;
    x.status = ST_OK;
    x.last   = 1'b0;
    return x;
  endfunction

  // one byte of the version or of a header line
  function automatic void line_data(inout pst_t ls, input logic [7:0] b, input logic last,
                                    output res_t lr);
    cls_e c;
    fld_e f;
    c = CLS_HNAME;
    f = FLD_NONE;
    if (ls.phase == PH_VERSION) begin
      lr = mk(b, CLS_VERSION, 5'd0, FLD_NONE, MTH_UNKNOWN);
    end else begin
      ls.line_empty = 1'b0;
      if (ls.hdrs >= HdrW'(HEADER_SLOTS)) begin
        lr = mk(b, CLS_DISCARD, 5'd0, FLD_NONE, MTH_UNKNOWN);
      end else if (!ls.colon && b == CH_COLON) begin
        ls.colon   = 1'b1;
        ls.skip_sp = 1'b1;
        lr = mk(b, CLS_DELIM, ls.hdrs[4:0], FLD_HNAME, MTH_UNKNOWN);
      end else begin
        if (!ls.colon) begin
          c = CLS_HNAME;
        end else if (ls.skip_sp && b == CH_SPACE) begin
          c = CLS_DISCARD;
        end else begin
          ls.skip_sp = 1'b0;
          c = CLS_HVALUE;
        end
        if (last) f = ls.colon ? FLD_HVALUE : FLD_DROPPED;
        lr = mk(b, c, ls.hdrs[4:0], f, MTH_UNKNOWN);
      end
    end
  endfunction

  always_comb begin
    s      = st_q;
    n      = 2'd0;
    done   = 1'b0;
    code   = MTH_UNKNOWN;
    r      = mk(8'h00, CLS_BODY, 5'd0, FLD_NONE, MTH_UNKNOWN);
    res[0] = r;
    res[1] = r;

    if (s.held) begin
      s.held = 1'b0;
      if (byte_i == CH_LF) begin
        done = 1'b1;
        n    = 2'd2;
        if (s.phase == PH_VERSION) begin
          res[0]  = mk(CH_CR, CLS_DELIM, 5'd0, FLD_VERSION, MTH_UNKNOWN);
          res[1]  = mk(CH_LF, CLS_DELIM, 5'd0, FLD_NONE, MTH_UNKNOWN);
          s.phase = PH_HEADER;
        end else if (s.line_empty) begin
          res[0]  = mk(CH_CR, CLS_DELIM, 5'd0, FLD_NONE, MTH_UNKNOWN);
          res[1]  = mk(CH_LF, CLS_DELIM, 5'd0, FLD_NONE, MTH_UNKNOWN);
          s.phase = PH_BODY;
        end else if (s.hdrs >= HdrW'(HEADER_SLOTS)) begin
          res[0] = mk(CH_CR, CLS_DELIM, 5'd0, FLD_NONE, MTH_UNKNOWN);
          res[1] = mk(CH_LF, CLS_DELIM, 5'd0, FLD_NONE, MTH_UNKNOWN);
        end else begin
          res[0] = mk(CH_CR, CLS_DELIM, s.hdrs[4:0],
                      s.colon ? FLD_HVALUE : FLD_DROPPED, MTH_UNKNOWN);
          res[1] = mk(CH_LF, CLS_DELIM, s.hdrs[4:0], FLD_NONE, MTH_UNKNOWN);
          if (s.colon) s.hdrs = s.hdrs + HdrW'(1);
        end
        s.colon      = 1'b0;
        s.line_empty = 1'b1;
        s.skip_sp    = 1'b0;
      end else begin
        // the held CR was plain data of its line
        line_data(s, CH_CR, 1'b0, r);
        res[0] = r;
        n      = 2'd1;
      end
    end

    if (!done) begin
      r = mk(byte_i, CLS_BODY, 5'd0, FLD_NONE, MTH_UNKNOWN);
      unique case (s.phase)
        PH_METHOD: begin
          if (byte_i == CH_SPACE) begin
            for (int k = 0; k < 5; k++) begin
              if (s.cand[k] && verb_len(3'(k)) == s.mlen) code = mth_e'(3'(k + 1));
            end
            r       = mk(byte_i, CLS_DELIM, 5'd0, FLD_METHOD, code);
            s.phase = PH_PATH;
          end else begin
            for (int k = 0; k < 5; k++) begin
              if (s.mlen >= verb_len(3'(k)) || verb_char(3'(k), s.mlen) != byte_i)
                s.cand[k] = 1'b0;
            end
            if (s.mlen != 3'd7) s.mlen = s.mlen + 3'd1;
            r = mk(byte_i, CLS_METHOD, 5'd0, FLD_NONE, MTH_UNKNOWN);
          end
        end
        PH_PATH: begin
          if (byte_i == CH_SPACE) begin
            r       = mk(byte_i, CLS_DELIM, 5'd0, FLD_PATH, MTH_UNKNOWN);
            s.phase = PH_VERSION;
          end else if (byte_i == CH_QMARK) begin
            r            = mk(byte_i, CLS_DELIM, 5'd0, FLD_PATH, MTH_UNKNOWN);
            s.phase      = PH_QUERY;
            s.pairs      = '0;
            s.has_eq     = 1'b0;
            s.pair_empty = 1'b1;
            s.q_halted   = 1'b0;
          end else begin
            r = mk(byte_i, CLS_PATH, 5'd0, FLD_NONE, MTH_UNKNOWN);
          end
        end
        PH_QUERY: begin
          if (byte_i == CH_SPACE) begin
            if (!s.q_halted && !s.pair_empty)
              r = mk(byte_i, CLS_DELIM, 5'(s.pairs),
                     s.has_eq ? FLD_QVALUE : FLD_QNAME, MTH_UNKNOWN);
            else
              r = mk(byte_i, CLS_DELIM, 5'd0, FLD_NONE, MTH_UNKNOWN);
            s.phase = PH_VERSION;
          end else if (s.q_halted) begin
            r = mk(byte_i, CLS_DISCARD, 5'd0, FLD_NONE, MTH_UNKNOWN);
          end else if (byte_i == CH_AMP) begin
            r = mk(byte_i, CLS_DELIM, 5'(s.pairs),
                   s.has_eq ? FLD_QVALUE : FLD_QNAME, MTH_UNKNOWN);
            if ((PairW + 1)'(s.pairs) + (PairW + 1)'(1) >= (PairW + 1)'(QUERY_SLOTS))
              s.q_halted = 1'b1;
            else
              s.pairs = s.pairs + PairW'(1);
            s.has_eq     = 1'b0;
            s.pair_empty = 1'b1;
          end else if (byte_i == CH_EQ && !s.has_eq) begin
            s.has_eq     = 1'b1;
            s.pair_empty = 1'b0;
            r = mk(byte_i, CLS_DELIM, 5'(s.pairs), FLD_QNAME, MTH_UNKNOWN);
          end else begin
            s.pair_empty = 1'b0;
            r = mk(byte_i, s.has_eq ? CLS_QVALUE : CLS_QNAME, 5'(s.pairs),
                   FLD_NONE, MTH_UNKNOWN);
          end
        end
        PH_VERSION, PH_HEADER: begin
          if (byte_i == CH_CR && !end_i) s.held = 1'b1;
          else line_data(s, byte_i, end_i, r);
        end
        default: begin
          r = mk(byte_i, CLS_BODY, 5'd0, FLD_NONE, MTH_UNKNOWN);
        end
      endcase
      if (!s.held) begin
        res[n[0]] = r;
        n         = n + 2'd1;
      end
    end

    if (n != 2'd0) begin
      res[n[1]].last = 1'b1;
      if (end_i) begin
        case (s.phase)
          PH_METHOD:           res[n[1]].status = ST_NO_SP_METHOD;
          PH_PATH, PH_QUERY:   res[n[1]].status = ST_NO_SP_PATH;
          PH_VERSION:          res[n[1]].status = ST_NO_EOL;
          default:             res[n[1]].status = ST_OK;
        endcase
      end
    end

    st_d        = end_i ? PST_RESET : s;
    push_o.cnt  = advance_i ? n : 2'd0;
    push_o.r0   = res[0];
    push_o.r1   = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PST_RESET;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

  a_held_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.held |-> (st_q.phase == PH_VERSION || st_q.phase == PH_HEADER))
    else $error("CR held outside version or header phase");

  a_pairs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PairW + 1)'(st_q.pairs) < (PairW + 1)'(QUERY_SLOTS))
    else $error("pair count beyond query slots");

  a_hdrs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.hdrs <= HdrW'(HEADER_SLOTS))
    else $error("header count beyond header slots");

  a_no_result_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && push_o.cnt == 2'd0) |=> st_q.held)
    else $error("byte gave no result without holding a CR");

endmodule

// File: rtl/core/htok_outq.sv
module htok_outq
  import htok_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  head_o
);

  localparam int PtrW = $clog2(OutqDepth);
  localparam int CntW = $clog2(OutqDepth + 1);

  res_t            mem [OutqDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem[rptr_q];
  // leave space for a CR LF pair
  assign room_o  = (cnt_q <= CntW'(OutqDepth - 2));

  always_comb begin
    wptr_d = wptr_q + PtrW'(push_i.cnt);
    rptr_d = rptr_q + PtrW'(pop);
    cnt_d  = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem[wptr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem[wptr_q + PtrW'(1)] <= push_i.r1;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(OutqDepth))
    else $error("output queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("push into output queue without room");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd0 && !pop) |=> $stable(cnt_q))
    else $error("queue fill changed without push or pop");

endmodule

// File: rtl/core/http_request_tokenizer_top.sv
// HTTP/1.1 request tokenizer. Feed request bytes on the slave stream, one byte per
// transaction, with tlast on the final byte of each request; every byte comes back on
// the master stream tagged with its class, query pair or header index, the field it
// closes and, where the method closes, the method code. A CR in the version or header
// part is held until the next byte, so a CR LF pair comes out as two transactions on
// the LF and the CR itself gives none; tlast on the output marks the last transaction
// caused by an input byte, and the final one of a request carries the parse status.
// Input is taken at one byte per clock while the output queue has room: a byte passes an
// input register, combinational classification logic and a four-entry output queue, so
// a result shows on the master stream once the byte has been written into the queue.
// The queue takes new bytes while it holds two entries or fewer, which sustains one
// byte per clock whenever the output side is ready. After the final byte all parser
// state returns to its reset values for the next request.
module http_request_tokenizer_top
  import htok_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // end_of_request
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] byte_out, [11:8] byte_class, [16:12] item_index, [20:17] closed_field,
  // [23:21] method_code, [25:24] parse_status, [31:26] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast    // last_of_run
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       room;
  logic       advance;
  push_t      push;
  res_t       head;

  assign advance       = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  htok_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .end_i     (in_end_q),
    .push_o    (push)
  );

  htok_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {6'b0, head.status, head.code, head.fld, head.idx, head.cls,
                         head.data};
  assign m_axis_tlast = head.last;

endmodule
